@@ rtl/core/crp_pkg.sv @@
// Shared constants and types of the cluster sampler.
package crp_pkg;

   localparam int unsigned MAX_CLUSTERS  = 1024;
   localparam int unsigned MAX_CUSTOMERS = 65536;
   localparam int unsigned DRAW_BITS     = 16;

   localparam int unsigned CLUSTER_AW = $clog2(MAX_CLUSTERS);       // memory address
   localparam int unsigned CLUSTER_CW = CLUSTER_AW + 1;             // open cluster count
   localparam int unsigned CUST_W     = $clog2(MAX_CUSTOMERS) + 1;  // seated count
   localparam int unsigned SIZE_W     = 17;                         // one cluster size
   localparam int unsigned ALPHA_W    = 16;
   localparam int unsigned SUM_W      = CUST_W + 8;                 // alpha + i in U.8, carry
   localparam int unsigned PROD_W     = SUM_W + DRAW_BITS;
   localparam int unsigned DIFF_HI_W  = PROD_W - 8 - DRAW_BITS;     // excess in whole customers
   localparam int unsigned CUM_W      = CUST_W + 1;
   localparam int unsigned ID_W       = 11;
   localparam int unsigned CSR_AW     = 3;
   localparam int unsigned CSR_DW     = 32;

   localparam logic [CSR_AW-3:0]  REG_CONCENTRATION = '0;
   localparam logic [ALPHA_W-1:0] CONCENTRATION_RST = 16'd256;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MULT   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

@@ rtl/core/crp_cluster_sampler.sv @@
// Chinese restaurant process sampler: seats one customer per request beat.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  req     | in        | req_valid / req_stall      | req_start_run, req_uniform_draw
//  rsp     | out       | rsp_valid / rsp_stall      | rsp_cluster_id, rsp_new_cluster,
//          |           |                            | rsp_overflow
//  csr     | in/out    | APB psel/penable/pready    | concentration at byte address 0
//
// A customer that opens a new cluster or overflows passes through MULT, DECIDE and DONE;
// one that joins cluster k (1-based) also walks clusters 1 to k in WALK: the walk reads one
// cluster size per cycle from the single-port size memory, so the open cluster count
// bounds the time. One customer is in flight at a time; req_stall is high while it is.
// A finished beat waits in the result register, so the next customer is taken while
// rsp_stall holds the previous result. Synchronous reset clears the counters and sets
// alpha to 1.0; the size memory needs no clearing, as each entry is written on opening.
module crp_cluster_sampler
   import crp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_run,
   input  logic [15:0]           req_uniform_draw,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ID_W-1:0]       rsp_cluster_id,
   output logic                  rsp_new_cluster,
   output logic                  rsp_overflow,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------- control state
   state_type             state_ff, state_in;
   logic [ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic [CUST_W-1:0]     customers_ff, customers_in;
   logic [CLUSTER_CW-1:0] clusters_ff, clusters_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------- datapath
   logic [DRAW_BITS-1:0]  draw_ff, draw_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIFF_HI_W-1:0]  excess_ff, excess_in;
   logic [CUM_W-1:0]      cum_ff, cum_in;
   logic [CLUSTER_AW-1:0] walk_ff, walk_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic                  new_ff, new_in;
   logic                  ovf_ff, ovf_in;
   // result staged before it enters the output register
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic                  res_new_ff, res_new_in;
   logic                  res_ovf_ff, res_ovf_in;

   // ---------------------------------------------------------------- size memory
   logic [SIZE_W-1:0]     size_mem [MAX_CLUSTERS];
   logic [SIZE_W-1:0]     size_rd_ff;
   logic [CLUSTER_AW-1:0] rd_addr;
   logic                  rd_en;
   logic [CLUSTER_AW-1:0] wr_addr;
   logic [SIZE_W-1:0]     wr_data;
   logic                  wr_en;

   // ---------------------------------------------------------------- helpers
   logic                  req_beat;
   logic                  csr_write;
   logic [SUM_W-1:0]      sum;
   logic                  cust_full;
   logic                  open_new;
   logic                  clusters_full;
   logic [PROD_W-1:0]     excess_full;
   logic [CUM_W-1:0]      cum_next;
   logic                  hit;
   logic                  last;
   logic                  out_free;

   assign req_beat  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_CONCENTRATION) ?
                       {{(CSR_DW-ALPHA_W){1'b0}}, alpha_ff} : '0;

   // alpha + i in U.8; only meaningful while the customer store has room
   assign sum = SUM_W'(alpha_ff) + SUM_W'({customers_ff[CUST_W-2:0], 8'd0});

   assign cust_full     = customers_ff[CUST_W-1];
   assign open_new      = (clusters_ff == '0) ||
                          (prod_ff < PROD_W'({alpha_ff, {DRAW_BITS{1'b0}}}));
   assign clusters_full = clusters_ff[CLUSTER_CW-1];
   assign excess_full   = prod_ff - PROD_W'({alpha_ff, {DRAW_BITS{1'b0}}});

   // lhs < (alpha + cum)<<16 reduces to whole-customer excess < cum
   assign cum_next = cum_ff + CUM_W'(size_rd_ff);
   assign hit      = CUM_W'(excess_ff) < cum_next;
   assign last     = ({1'b0, walk_ff} == (clusters_ff - CLUSTER_CW'(1)));

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      customers_in = customers_ff;
      clusters_in  = clusters_ff;
      rsp_valid_in = rsp_valid_ff;
      draw_in      = draw_ff;
      prod_in      = prod_ff;
      excess_in    = excess_ff;
      cum_in       = cum_ff;
      walk_in      = walk_ff;
      id_in        = id_ff;
      new_in       = new_ff;
      ovf_in       = ovf_ff;
      res_id_in    = res_id_ff;
      res_new_in   = res_new_ff;
      res_ovf_in   = res_ovf_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = walk_ff;
      wr_data      = size_rd_ff + SIZE_W'(1);

      if (csr_write && (csr_paddr[CSR_AW-1:2] == REG_CONCENTRATION)) begin
         alpha_in = csr_pwdata[ALPHA_W-1:0];
      end

      // drop the taken beat
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               draw_in = req_uniform_draw[DRAW_BITS-1:0];
               // a new run empties the restaurant before this customer sits
               if (req_start_run) begin
                  customers_in = '0;
                  clusters_in  = '0;
               end
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(sum) * PROD_W'(draw_ff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            excess_in = excess_full[PROD_W-1 -: DIFF_HI_W];
            cum_in    = '0;
            walk_in   = '0;
            if (cust_full || (open_new && clusters_full)) begin
               res_id_in  = '0;
               res_new_in = 1'b0;
               res_ovf_in = 1'b1;
               state_in   = ST_DONE;
            end else if (open_new) begin
               wr_en        = 1'b1;
               wr_addr      = clusters_ff[CLUSTER_AW-1:0];
               wr_data      = SIZE_W'(1);
               clusters_in  = clusters_ff + CLUSTER_CW'(1);
               customers_in = customers_ff + CUST_W'(1);
               res_id_in    = ID_W'(clusters_ff) + ID_W'(1);
               res_new_in   = 1'b1;
               res_ovf_in   = 1'b0;
               state_in     = ST_DONE;
            end else begin
               // fetch the first size; it lands in size_rd_ff next cycle
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit || last) begin
               // join this cluster: write back its size plus one
               wr_en        = 1'b1;
               wr_addr      = walk_ff;
               wr_data      = size_rd_ff + SIZE_W'(1);
               customers_in = customers_ff + CUST_W'(1);
               res_id_in    = ID_W'(walk_ff) + ID_W'(1);
               res_new_in   = 1'b0;
               res_ovf_in   = 1'b0;
               state_in     = ST_DONE;
            end else begin
               // advance to the next cluster
               cum_in  = cum_next;
               walk_in = walk_ff + CLUSTER_AW'(1);
               rd_en   = 1'b1;
               rd_addr = walk_ff + CLUSTER_AW'(1);
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               id_in        = res_id_ff;
               new_in       = res_new_ff;
               ovf_in       = res_ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= CONCENTRATION_RST;
         customers_ff <= '0;
         clusters_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         customers_ff <= customers_in;
         clusters_ff  <= clusters_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff    <= draw_in;
      prod_ff    <= prod_in;
      excess_ff  <= excess_in;
      cum_ff     <= cum_in;
      walk_ff    <= walk_in;
      id_ff      <= id_in;
      new_ff     <= new_in;
      ovf_ff     <= ovf_in;
      res_id_ff  <= res_id_in;
      res_new_ff <= res_new_in;
      res_ovf_ff <= res_ovf_in;
   end

   // single-port size store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         size_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         size_rd_ff <= size_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cluster_id  = id_ff;
   assign rsp_new_cluster = new_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

@@ sim/crp_cluster_sampler_tb.sv @@
// Self-checking testbench of the cluster sampler: directed table, then random seating runs.
module crp_cluster_sampler_tb
   import crp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One result beat as the sampler presents it.
   typedef struct packed {
      logic [ID_W-1:0] cluster_id;
      logic            fresh;
      logic            ovf;
   } seat_type;

   // One row of the directed table. The start flag applies to the first beat of a row only,
   // so a row with many beats seats a whole run of customers.
   typedef struct packed {
      bit        set_alpha;
      bit [15:0] alpha;
      bit        start;
      bit [15:0] draw;
      bit [16:0] beats;
      bit        typed;
      seat_type  want;
   } seat_row_type;

   localparam int unsigned CYCLE_LIMIT      = 3_000_000;
   localparam int unsigned SETTLE_CYCLES    = 64;
   localparam int unsigned RANDOM_PHASES    = 6;
   localparam int unsigned RANDOM_PER_PHASE = 317;
   localparam int unsigned PACED_BEATS_MAX  = 64;
   localparam int unsigned PRINT_LIMIT      = 50;

   localparam logic [CSR_AW-1:0] CONC_ADDR = {REG_CONCENTRATION, 2'b00};

   localparam seat_type OPENS_FIRST = '{cluster_id: 11'd1, fresh: 1'b1, ovf: 1'b0};
   localparam seat_type JOINS_FIRST = '{cluster_id: 11'd1, fresh: 1'b0, ovf: 1'b0};
   localparam seat_type STORE_FULL  = '{cluster_id: 11'd0, fresh: 1'b0, ovf: 1'b1};
   localparam seat_type PREDICTED   = '0;

   localparam int ROW_COUNT = 21;

   // Rows marked typed carry a result that can be read straight off the behaviour; the rest
   // take the predictor's answer.
   localparam seat_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      // first customer after reset opens cluster 1, then a top draw joins it
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 17'd1,     1'b1, OPENS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'hFFFF, 17'd1,     1'b1, JOINS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'h8000, 17'd1,     1'b0, PREDICTED},
      '{1'b0, 16'h0000, 1'b0, 16'h0001, 17'd1,     1'b0, PREDICTED},
      // start of run clears both counters
      '{1'b0, 16'h0000, 1'b1, 16'hFFFF, 17'd1,     1'b1, OPENS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'h7FFF, 17'd6,     1'b0, PREDICTED},
      // largest concentration
      '{1'b1, 16'hFFFF, 1'b1, 16'h0000, 17'd1,     1'b1, OPENS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'hFFFF, 17'd8,     1'b0, PREDICTED},
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 17'd1,     1'b0, PREDICTED},
      // zero concentration: only the first customer of a run opens a cluster
      '{1'b1, 16'h0000, 1'b1, 16'h1234, 17'd1,     1'b1, OPENS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 17'd1,     1'b1, JOINS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'hFFFF, 17'd4,     1'b1, JOINS_FIRST},
      // smallest concentration; a zero draw always opens, so fill the cluster store
      '{1'b1, 16'h0001, 1'b1, 16'h0000, 17'd1024,  1'b0, PREDICTED},
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 17'd1,     1'b1, STORE_FULL},
      // joining still works with the cluster store full; the top draw walks to the end
      '{1'b0, 16'h0000, 1'b0, 16'hFFFF, 17'd1,     1'b0, PREDICTED},
      '{1'b0, 16'h0000, 1'b0, 16'h8000, 17'd1,     1'b0, PREDICTED},
      // start of run on a full store, then fill the customer count through one cluster
      '{1'b0, 16'h0000, 1'b1, 16'h0000, 17'd1,     1'b1, OPENS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'hFFFF, 17'd65535, 1'b1, JOINS_FIRST},
      '{1'b0, 16'h0000, 1'b0, 16'hFFFF, 17'd1,     1'b1, STORE_FULL},
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 17'd1,     1'b1, STORE_FULL},
      '{1'b0, 16'h0000, 1'b1, 16'h5555, 17'd1,     1'b1, OPENS_FIRST}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_start_run = 1'b0;
   logic [15:0]       req_uniform_draw = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ID_W-1:0]   rsp_cluster_id;
   logic              rsp_new_cluster;
   logic              rsp_overflow;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Predictor's copy of the sampler state and its one register.
   bit [CUST_W-1:0]     seated_count;
   bit [CLUSTER_CW-1:0] open_clusters;
   bit [SIZE_W-1:0]     cluster_size [MAX_CLUSTERS];
   bit [ALPHA_W-1:0]    alpha_q = CONCENTRATION_RST;

   seat_type    expected_seats [$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   bit          pacing      = 1'b1;
   int unsigned burst_left  = 0;
   int unsigned pattern_left = 0;
   int unsigned stall_pct   = 0;

   crp_cluster_sampler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_run    (req_start_run),
      .req_uniform_draw (req_uniform_draw),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cluster_id   (rsp_cluster_id),
      .rsp_new_cluster  (rsp_new_cluster),
      .rsp_overflow     (rsp_overflow),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < PRINT_LIMIT)
         $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                  cycle_count);
      mismatches++;
   endtask

   // Seat one customer in the predictor's state and return the beat it should produce.
   // The draw is weighed as (alpha + i) * u against alpha and the running cluster sizes,
   // everything scaled by 2^(8 + DRAW_BITS) so the comparisons stay exact.
   function automatic seat_type predict_seat(input bit start, input bit [15:0] draw);
      seat_type    seat;
      bit [63:0]   weighted;
      bit [63:0]   running;
      bit          opens;
      bit          found;
      int unsigned pick;
      seat = STORE_FULL;
      if (start) begin
         seated_count  = '0;
         open_clusters = '0;
      end
      if (seated_count >= MAX_CUSTOMERS)
         return seat;
      weighted = (64'(alpha_q) + (64'(seated_count) << 8)) * 64'(draw);
      opens = (open_clusters == 0) || (weighted < (64'(alpha_q) << DRAW_BITS));
      if (opens) begin
         if (open_clusters >= MAX_CLUSTERS)
            return seat;
         pick = open_clusters;
         cluster_size[pick] = SIZE_W'(1);
         open_clusters++;
      end else begin
         // walk the sizes in cluster order; fall back to the last cluster
         running = '0;
         found   = 1'b0;
         pick    = open_clusters - 1;
         for (int j = 0; j < open_clusters && !found; j++) begin
            running += 64'(cluster_size[j]);
            if (weighted < ((64'(alpha_q) + (running << 8)) << DRAW_BITS)) begin
               pick  = j;
               found = 1'b1;
            end
         end
         cluster_size[pick] = cluster_size[pick] + 1'b1;
      end
      seated_count++;
      seat.cluster_id = ID_W'(pick + 1);
      seat.fresh      = opens;
      seat.ovf        = 1'b0;
      return seat;
   endfunction

   // One APB transfer to the concentration register. Leave psel high afterwards so a
   // second transfer can follow at once; the caller drops it.
   task automatic csr_access(input bit is_write, input bit [ALPHA_W-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CONC_ADDR;
      csr_pwdata  <= CSR_DW'(wdata);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   // Let the sampler go idle, then write alpha and read it back.
   task automatic write_concentration(input bit [ALPHA_W-1:0] value);
      logic [CSR_DW-1:0] readback;
      req_valid <= 1'b0;
      while (expected_seats.size() != 0)
         @(posedge clock);
      csr_access(1'b1, value, readback);
      alpha_q = value;
      csr_access(1'b0, '0, readback);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DW'(value))
         report_mismatch("concentration readback", readback, value);
   endtask

   // Offer one customer beat, hold it until taken, then queue what it should produce.
   // While pacing, the sender works in bursts and drops valid for a random gap between them.
   task automatic send_seat(input bit start, input bit [15:0] draw, input bit typed,
                            input seat_type want);
      seat_type predicted;
      if (pacing && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_valid        <= 1'b1;
      req_start_run    <= start;
      req_uniform_draw <= draw;
      do @(posedge clock); while (req_stall);
      predicted = predict_seat(start, draw);
      expected_seats.push_back(typed ? want : predicted);
   endtask

   // Receiver: stall with a random duty that is redrawn whenever its pattern runs out, including stretches
   // with no stall at all. Hold off stalling entirely while pacing is off.
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         pattern_left <= $urandom_range(8, 64);
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 20;
            2: stall_pct <= 50;
            default: stall_pct <= 85;
         endcase
      end else begin
         pattern_left <= pattern_left - 1;
      end
      rsp_stall <= pacing && ($urandom_range(0, 99) < stall_pct);
   end

   // Result checker: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      seat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_seats.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_cluster_id, 0);
         end else begin
            want = expected_seats.pop_front();
            if (rsp_cluster_id !== want.cluster_id)
               report_mismatch("cluster_id", rsp_cluster_id, want.cluster_id);
            if (rsp_new_cluster !== want.fresh)
               report_mismatch("new_cluster", rsp_new_cluster, want.fresh);
            if (rsp_overflow !== want.ovf)
               report_mismatch("overflow", rsp_overflow, want.ovf);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [CSR_DW-1:0] readback;
      bit [15:0]         draw;
      bit [15:0]         alpha;
      bit                fresh_run;
      int unsigned       run_left;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // alpha must come up as 1.0
      csr_access(1'b0, '0, readback);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DW'(CONCENTRATION_RST))
         report_mismatch("concentration after reset", readback, CONCENTRATION_RST);

      // Directed part. Drop pacing for the long fill rows to keep the run short.
      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].set_alpha)
            write_concentration(DIRECTED_ROWS[r].alpha);
         pacing = (DIRECTED_ROWS[r].beats <= PACED_BEATS_MAX);
         for (int unsigned b = 0; b < DIRECTED_ROWS[r].beats; b++)
            send_seat(DIRECTED_ROWS[r].start && b == 0, DIRECTED_ROWS[r].draw,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
      pacing = 1'b1;

      // Random part: one phase per alpha setting. Each phase is mostly runs of customers
      // opened by a start beat, most short, a few long enough for deep walks, with the
      // odd stray start in the middle of a run.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: alpha = 16'h0001;
            1: alpha = 16'hFFFF;
            2: alpha = CONCENTRATION_RST;
            default: alpha = 16'($urandom_range(1, 65535));
         endcase
         write_concentration(alpha);
         run_left = 0;
         for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
            fresh_run = (run_left == 0);
            if (fresh_run)
               run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 60);
            run_left--;
            case ($urandom_range(0, 9))
               0: draw = 16'h0000;
               1: draw = 16'hFFFF;
               2: draw = 16'($urandom_range(0, 255));
               default: draw = 16'($urandom);
            endcase
            send_seat(fresh_run || ($urandom_range(0, 63) == 0), draw, 1'b0, PREDICTED);
         end
      end

      // Drain: wait for every expected beat, then give stray beats a chance to show.
      req_valid <= 1'b0;
      while (expected_seats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/crp_pkg.sv
rtl/core/crp_cluster_sampler.sv
sim/crp_cluster_sampler_tb.sv
